FILE: hw/rtl/ppr_pkg.sv
// ppr_pkg: shared types and constants for the packed pixel to RGB888 core.
// Depends on nothing; imported by every module in hw/rtl.
package ppr_pkg;

    localparam int CFG_W  = 13;
    localparam int WORD_W = 32;
    localparam int CHAN_W = 8;
    localparam int SUM_W  = 27;

    typedef logic [1:0] fmt_t;
    localparam fmt_t FMT_YUYV   = 2'd0;
    localparam fmt_t FMT_UYVY   = 2'd1;
    localparam fmt_t FMT_RGB565 = 2'd2;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_FORMAT = 2'd0;
    localparam reg_idx_t REG_WIDTH  = 2'd1;
    localparam reg_idx_t REG_HEIGHT = 2'd2;

    localparam fmt_t             RST_FORMAT = FMT_YUYV;
    localparam logic [CFG_W-1:0] RST_WIDTH  = 13'd1920;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 13'd1080;

    // full range, Q16
    localparam logic signed [SUM_W-1:0] Q16_V_TO_R = 27'sd91881;
    localparam logic signed [SUM_W-1:0] Q16_U_TO_G = 27'sd22554;
    localparam logic signed [SUM_W-1:0] Q16_V_TO_G = 27'sd46802;
    localparam logic signed [SUM_W-1:0] Q16_U_TO_B = 27'sd116130;

    // BT.601 limited range, Q8
    localparam logic signed [SUM_W-1:0] Q8_Y     = 27'sd298;
    localparam logic signed [SUM_W-1:0] Q8_V_R   = 27'sd409;
    localparam logic signed [SUM_W-1:0] Q8_U_G   = 27'sd100;
    localparam logic signed [SUM_W-1:0] Q8_V_G   = 27'sd208;
    localparam logic signed [SUM_W-1:0] Q8_U_B   = 27'sd516;
    localparam logic signed [SUM_W-1:0] Q8_ROUND = 27'sd128;

    typedef struct packed {
        logic s1_load;
        logic s2_load;
    } ppr_ctl_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

endpackage

FILE: hw/rtl/ppr_lane.sv
// ppr_lane: converts one pixel (YUV or RGB565) to RGB888 in two stages.
// Stage 1 registers the coefficient products, stage 2 sums and clamps.
// Depends on ppr_pkg.
module ppr_lane (
    input  logic                clk,
    input  ppr_pkg::ppr_ctl_t   ctl,
    input  ppr_pkg::fmt_t       fmt,
    input  logic [7:0]          y,
    input  logic [7:0]          u,
    input  logic [7:0]          v,
    input  logic [15:0]         p565,
    output ppr_pkg::rgb_t       rgb
);
    import ppr_pkg::*;

    logic signed [SUM_W-1:0] y_term_reg, r_term_reg, gu_term_reg, gv_term_reg, b_term_reg;
    logic signed [SUM_W-1:0] y_term_next, r_term_next, gu_term_next, gv_term_next, b_term_next;
    fmt_t                    fmt_reg;
    logic [15:0]             p565_reg;
    rgb_t                    rgb_reg, rgb_next;

    logic [8:0]              du9, dv9, yc9;
    logic signed [SUM_W-1:0] du, dv, yc;
    logic signed [SUM_W-1:0] r_sum, g_sum, b_sum;
    logic [4:0]              r5, b5;
    logic [5:0]              g6;

    function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [SUM_W-1:0] s,
                                                     input logic q16);
        logic [SUM_W-1:0] sh;
        logic [CHAN_W-1:0] res;
        sh = q16 ? (SUM_W)'($unsigned(s) >> 16) : (SUM_W)'($unsigned(s) >> 8);
        if (s < 0)
        begin
            res = '0;
        end
        else if (sh > (SUM_W)'(255))
        begin
            res = 8'hFF;
        end
        else
        begin
            res = sh[CHAN_W-1:0];
        end
        return res;
    endfunction

    always_comb
    begin
        du9 = {1'b0, u} - 9'd128;
        dv9 = {1'b0, v} - 9'd128;
        yc9 = {1'b0, y} - 9'd16;
        du  = {{(SUM_W-9){du9[8]}}, du9};
        dv  = {{(SUM_W-9){dv9[8]}}, dv9};
        yc  = {{(SUM_W-9){yc9[8]}}, yc9};
        y_term_next  = '0;
        r_term_next  = '0;
        gu_term_next = '0;
        gv_term_next = '0;
        b_term_next  = '0;
        case (fmt)
            FMT_YUYV:
            begin
                y_term_next  = {3'b000, y, 16'h0000};
                r_term_next  = dv * Q16_V_TO_R;
                gu_term_next = -(du * Q16_U_TO_G);
                gv_term_next = -(dv * Q16_V_TO_G);
                b_term_next  = du * Q16_U_TO_B;
            end
            FMT_UYVY:
            begin
                y_term_next  = yc * Q8_Y + Q8_ROUND;
                r_term_next  = dv * Q8_V_R;
                gu_term_next = -(du * Q8_U_G);
                gv_term_next = -(dv * Q8_V_G);
                b_term_next  = du * Q8_U_B;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s1_load)
        begin
            y_term_reg  <= y_term_next;
            r_term_reg  <= r_term_next;
            gu_term_reg <= gu_term_next;
            gv_term_reg <= gv_term_next;
            b_term_reg  <= b_term_next;
            fmt_reg     <= fmt;
            p565_reg    <= p565;
        end
    end

    always_comb
    begin
        r_sum = y_term_reg + r_term_reg;
        g_sum = y_term_reg + gu_term_reg + gv_term_reg;
        b_sum = y_term_reg + b_term_reg;
        r5 = p565_reg[15:11];
        g6 = p565_reg[10:5];
        b5 = p565_reg[4:0];
        case (fmt_reg)
            FMT_YUYV:
            begin
                rgb_next.red   = clamp_chan(r_sum, 1'b1);
                rgb_next.green = clamp_chan(g_sum, 1'b1);
                rgb_next.blue  = clamp_chan(b_sum, 1'b1);
            end
            FMT_UYVY:
            begin
                rgb_next.red   = clamp_chan(r_sum, 1'b0);
                rgb_next.green = clamp_chan(g_sum, 1'b0);
                rgb_next.blue  = clamp_chan(b_sum, 1'b0);
            end
            FMT_RGB565:
            begin
                rgb_next.red   = {r5, r5[4:2]};
                rgb_next.green = {g6, g6[5:4]};
                rgb_next.blue  = {b5, b5[4:2]};
            end
            default:
            begin
                rgb_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s2_load)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb = rgb_reg;

endmodule

FILE: hw/rtl/ppr_frame_ctr.sv
// ppr_frame_ctr: pair column and line row counters with end-of-line/frame flags.
// Limits are saturated to the supported range. Depends on ppr_pkg.
module ppr_frame_ctr #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic [ppr_pkg::CFG_W-1:0] frame_width,
    input  logic [ppr_pkg::CFG_W-1:0] frame_height,
    output logic                      end_of_line,
    output logic                      end_of_frame
);
    import ppr_pkg::*;

    localparam int COL_W = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int LIM_W = CFG_W + 1;
    localparam logic [LIM_W-1:0] MAX_W = LIM_W'(MAX_WIDTH);
    localparam logic [LIM_W-1:0] MAX_H = LIM_W'(MAX_HEIGHT);

    logic [COL_W-1:0] pair_column_reg, pair_column_next;
    logic [ROW_W-1:0] line_row_reg, line_row_next;
    logic [LIM_W-1:0] width_use, height_use, pairs;
    logic [LIM_W-1:0] col_inc, row_inc;

    always_comb
    begin
        width_use = {1'b0, frame_width};
        if (width_use < LIM_W'(2))
        begin
            width_use = LIM_W'(2);
        end
        else if (width_use > MAX_W)
        begin
            width_use = MAX_W;
        end
        height_use = {1'b0, frame_height};
        if (height_use < LIM_W'(1))
        begin
            height_use = LIM_W'(1);
        end
        else if (height_use > MAX_H)
        begin
            height_use = MAX_H;
        end
        pairs   = width_use >> 1;
        col_inc = LIM_W'(pair_column_reg) + LIM_W'(1);
        row_inc = LIM_W'(line_row_reg) + LIM_W'(1);

        end_of_line  = (col_inc >= pairs);
        end_of_frame = end_of_line && (row_inc >= height_use);

        pair_column_next = pair_column_reg;
        line_row_next    = line_row_reg;
        if (advance)
        begin
            if (end_of_line)
            begin
                pair_column_next = '0;
                line_row_next    = end_of_frame ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                pair_column_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_column_reg <= '0;
            line_row_reg    <= '0;
        end
        else
        begin
            pair_column_reg <= pair_column_next;
            line_row_reg    <= line_row_next;
        end
    end

endmodule

FILE: hw/rtl/packed_pixel_to_rgb888_core.sv
// packed_pixel_to_rgb888_core: top level, two conversion lanes, counters,
// configuration registers and pipeline control. Depends on ppr_pkg,
// ppr_lane and ppr_frame_ctr.
//
// Usage:
//  - Input channel data_valid/data_ready carries one 32-bit word per beat,
//    two pixels (YUYV, UYVY or two RGB565). Output channel pixel_valid/
//    pixel_ready carries two RGB888 pixels plus end_of_line/end_of_frame.
//  - Configuration: cfg_write with cfg_index (0 format, 1 width, 2 height)
//    and cfg_data; write only while the pipeline is empty.
//  - pixel_valid rises once the input beat has passed both registered
//    stages; throughput is one beat per cycle while pixel_ready stays
//    high. Each lane holds two registered stages (products, then
//    sum and clamp), and the second stage is the output register.
//  - When the receiver stalls, the input side keeps accepting until both
//    stages are full; bubbles collapse, so data_ready drops only then.
//  - Reset clears the stage valid bits and the line/frame counters and
//    loads format YUYV, width 1920, height 1080.
module packed_pixel_to_rgb888_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  ppr_pkg::reg_idx_t          cfg_index,
    input  logic [ppr_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       data_valid,
    output logic                       data_ready,
    input  logic [ppr_pkg::WORD_W-1:0] data_word,
    output logic                       pixel_valid,
    input  logic                       pixel_ready,
    output logic [7:0]                 red_first,
    output logic [7:0]                 green_first,
    output logic [7:0]                 blue_first,
    output logic [7:0]                 red_second,
    output logic [7:0]                 green_second,
    output logic [7:0]                 blue_second,
    output logic                       end_of_line,
    output logic                       end_of_frame
);
    import ppr_pkg::*;

    fmt_t             pixel_format_reg;
    logic [CFG_W-1:0] frame_width_reg, frame_height_reg;
    logic             s1_valid_reg, s2_valid_reg;
    logic             s1_valid_next, s2_valid_next;
    logic [1:0]       s1_flags_reg, s2_flags_reg;
    logic             eol, eof;
    ppr_ctl_t         ctl;
    logic [7:0]       y0, y1, uu, vv;
    rgb_t             rgb_a, rgb_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= RST_FORMAT;
            frame_width_reg  <= RST_WIDTH;
            frame_height_reg <= RST_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FORMAT: pixel_format_reg <= cfg_data[1:0];
                REG_WIDTH:  frame_width_reg  <= cfg_data;
                REG_HEIGHT: frame_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        ctl.s2_load   = s1_valid_reg && (!s2_valid_reg || pixel_ready);
        data_ready    = !s1_valid_reg || ctl.s2_load;
        ctl.s1_load   = data_valid && data_ready;
        s1_valid_next = ctl.s1_load ? 1'b1 : (ctl.s2_load ? 1'b0 : s1_valid_reg);
        s2_valid_next = ctl.s2_load ? 1'b1 : (pixel_ready ? 1'b0 : s2_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s1_load)
        begin
            s1_flags_reg <= {eof, eol};
        end
        if (ctl.s2_load)
        begin
            s2_flags_reg <= s1_flags_reg;
        end
    end

    ppr_frame_ctr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_frame_ctr (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (ctl.s1_load),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .end_of_line  (eol),
        .end_of_frame (eof)
    );

    // byte order: YUYV = Y0 U Y1 V, UYVY = U Y0 V Y1
    always_comb
    begin
        if (pixel_format_reg == FMT_UYVY)
        begin
            uu = data_word[7:0];
            y0 = data_word[15:8];
            vv = data_word[23:16];
            y1 = data_word[31:24];
        end
        else
        begin
            y0 = data_word[7:0];
            uu = data_word[15:8];
            y1 = data_word[23:16];
            vv = data_word[31:24];
        end
    end

    ppr_lane u_lane_first (
        .clk  (clk),
        .ctl  (ctl),
        .fmt  (pixel_format_reg),
        .y    (y0),
        .u    (uu),
        .v    (vv),
        .p565 (data_word[15:0]),
        .rgb  (rgb_a)
    );

    ppr_lane u_lane_second (
        .clk  (clk),
        .ctl  (ctl),
        .fmt  (pixel_format_reg),
        .y    (y1),
        .u    (uu),
        .v    (vv),
        .p565 (data_word[31:16]),
        .rgb  (rgb_b)
    );

    assign pixel_valid  = s2_valid_reg;
    assign red_first    = rgb_a.red;
    assign green_first  = rgb_a.green;
    assign blue_first   = rgb_a.blue;
    assign red_second   = rgb_b.red;
    assign green_second = rgb_b.green;
    assign blue_second  = rgb_b.blue;
    assign end_of_line  = s2_flags_reg[0];
    assign end_of_frame = s2_flags_reg[1];

endmodule

FILE: sim/tb_packed_pixel_to_rgb888_core.sv
// Self-checking testbench for packed_pixel_to_rgb888_core: YUYV, UYVY and RGB565 words
// against an in-bench pixel pair predictor, with random idling on both channels.
// Depends on ppr_pkg and the core RTL; reads no files.
module tb_packed_pixel_to_rgb888_core;

    timeunit 1ns;
    timeprecision 1ps;

    import ppr_pkg::*;

    localparam int MAX_W = 4096;
    localparam int MAX_H = 4096;
    localparam fmt_t     FMT_UNUSED = 2'd3;
    localparam reg_idx_t REG_SPARE  = 2'd3;

    typedef struct packed {
        rgb_t first;
        rgb_t second;
        logic eol;
        logic eof;
    } pixel_pair_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_write;
    reg_idx_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             data_valid;
    logic             data_ready;
    logic [31:0]      data_word;
    logic             pixel_valid;
    logic             pixel_ready;
    logic [7:0]       red_first;
    logic [7:0]       green_first;
    logic [7:0]       blue_first;
    logic [7:0]       red_second;
    logic [7:0]       green_second;
    logic [7:0]       blue_second;
    logic             end_of_line;
    logic             end_of_frame;

    // mirror of the configuration and the line/frame counters
    fmt_t             cur_fmt;
    logic [CFG_W-1:0] cur_width;
    logic [CFG_W-1:0] cur_height;
    int unsigned      exp_col;
    int unsigned      exp_row;

    pixel_pair_t pending_pairs[$];
    bit          src_gaps;
    bit          snk_stalls;
    int          errors;
    int          words_sent;
    int          pairs_checked;
    int          eol_seen;
    int          eof_seen;

    packed_pixel_to_rgb888_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data_word    (data_word),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .red_first    (red_first),
        .green_first  (green_first),
        .blue_first   (blue_first),
        .red_second   (red_second),
        .green_second (green_second),
        .blue_second  (blue_second),
        .end_of_line  (end_of_line),
        .end_of_frame (end_of_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_packed_pixel_to_rgb888_core: done, errors");
        $finish;
    end

    function automatic logic [7:0] q16_to_chan(input int s);
        if (s < 0)
            return 8'd0;
        if ((s >>> 16) > 255)
            return 8'hFF;
        return s[23:16];
    endfunction

    function automatic logic [7:0] q8_to_chan(input int s);
        if (s < 0)
            return 8'd0;
        if ((s >>> 8) > 255)
            return 8'hFF;
        return s[15:8];
    endfunction

    function automatic rgb_t full_range_rgb(input int y, input int u, input int v);
        rgb_t c;
        int   base;
        base = y * 65536;
        c.red   = q16_to_chan(base + 91881 * (v - 128));
        c.green = q16_to_chan(base - 22554 * (u - 128) - 46802 * (v - 128));
        c.blue  = q16_to_chan(base + 116130 * (u - 128));
        return c;
    endfunction

    function automatic rgb_t studio_range_rgb(input int y, input int u, input int v);
        rgb_t c;
        int   luma;
        luma = 298 * (y - 16);
        c.red   = q8_to_chan(luma + 409 * (v - 128) + 128);
        c.green = q8_to_chan(luma - 100 * (u - 128) - 208 * (v - 128) + 128);
        c.blue  = q8_to_chan(luma + 516 * (u - 128) + 128);
        return c;
    endfunction

    function automatic rgb_t expand_565(input logic [15:0] p);
        rgb_t c;
        c.red   = {p[15:11], p[15:13]};
        c.green = {p[10:5], p[10:9]};
        c.blue  = {p[4:0], p[4:2]};
        return c;
    endfunction

    function automatic pixel_pair_t predict_pair(input logic [31:0] w);
        pixel_pair_t p;
        int unsigned wid;
        int unsigned hgt;
        p = '0;
        case (cur_fmt)
            FMT_YUYV:
            begin
                p.first  = full_range_rgb(w[7:0], w[15:8], w[31:24]);
                p.second = full_range_rgb(w[23:16], w[15:8], w[31:24]);
            end
            FMT_UYVY:
            begin
                p.first  = studio_range_rgb(w[15:8], w[7:0], w[23:16]);
                p.second = studio_range_rgb(w[31:24], w[7:0], w[23:16]);
            end
            FMT_RGB565:
            begin
                p.first  = expand_565(w[15:0]);
                p.second = expand_565(w[31:16]);
            end
            default:
            begin
            end
        endcase
        wid = cur_width;
        hgt = cur_height;
        if (wid < 2)
            wid = 2;
        if (wid > MAX_W)
            wid = MAX_W;
        if (hgt < 1)
            hgt = 1;
        if (hgt > MAX_H)
            hgt = MAX_H;
        if (exp_col + 1 >= (wid >> 1))
        begin
            p.eol   = 1'b1;
            exp_col = 0;
            if (exp_row + 1 >= hgt)
            begin
                p.eof   = 1'b1;
                exp_row = 0;
            end
            else
                exp_row++;
        end
        else
            exp_col++;
        return p;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'd16;
            3: return 8'd235;
            4: return 8'd128;
            5: return 8'd127;
            6: return 8'd1;
            7: return 8'd240;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        if ($urandom_range(0, 2) == 0)
            return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        return $urandom();
    endfunction

    task automatic flag_error(input string what, input int got, input int want);
        $display("MISMATCH pair %0d %s: got %0h expected %0h", pairs_checked, what, got, want);
        errors++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            flag_error(what, got, want);
    endtask

    task automatic check_beat();
        pixel_pair_t want;
        if (pending_pairs.size() == 0)
        begin
            flag_error("unexpected beat", 1, 0);
            return;
        end
        want = pending_pairs.pop_front();
        check_field("red_first", red_first, want.first.red);
        check_field("green_first", green_first, want.first.green);
        check_field("blue_first", blue_first, want.first.blue);
        check_field("red_second", red_second, want.second.red);
        check_field("green_second", green_second, want.second.green);
        check_field("blue_second", blue_second, want.second.blue);
        check_field("end_of_line", end_of_line, want.eol);
        check_field("end_of_frame", end_of_frame, want.eof);
        pairs_checked++;
        eol_seen += want.eol;
        eof_seen += want.eof;
    endtask

    // receiver: random stall before each beat, checks on acceptance
    initial
    begin
        int stall;
        pixel_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = snk_stalls ? $urandom_range(0, 8) : 0;
            if (stall != 0)
            begin
                pixel_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pixel_ready <= 1'b1;
            do @(posedge clk); while (!pixel_valid);
            check_beat();
        end
    end

    task automatic send_word(input logic [31:0] w);
        int gap;
        gap = src_gaps ? $urandom_range(0, 8) : 0;
        if (gap != 0)
        begin
            data_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        data_valid <= 1'b1;
        data_word  <= w;
        do @(posedge clk); while (!data_ready);
        pending_pairs.push_back(predict_pair(w));
        words_sent++;
    endtask

    task automatic settle();
        data_valid <= 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_FORMAT: cur_fmt    = val[1:0];
            REG_WIDTH:  cur_width  = val;
            REG_HEIGHT: cur_height = val;
            default:
            begin
            end
        endcase
    endtask

    // one full line at the reset width, YUYV
    task automatic test_reset_defaults();
        src_gaps   = 0;
        snk_stalls = 0;
        repeat (960) send_word(rand_word());
        settle();
    endtask

    task automatic test_formats();
        src_gaps   = 1;
        snk_stalls = 1;
        write_reg(REG_WIDTH, 13'd4);
        write_reg(REG_HEIGHT, 13'd2);
        write_reg(REG_FORMAT, CFG_W'(FMT_YUYV));
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'h80FF_8000);
        send_word(32'hFF00_FF00);
        send_word(32'h00FF_00FF);
        settle();
        write_reg(REG_FORMAT, CFG_W'(FMT_UYVY));
        send_word(32'h1080_1080);
        send_word(32'hEB80_EB80);
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'h00FF_00FF);
        settle();
        write_reg(REG_FORMAT, CFG_W'(FMT_RGB565));
        send_word(32'h0000_FFFF);
        send_word(32'hF800_07E0);
        send_word(32'h001F_0841);
        send_word(32'hAAAA_5555);
        settle();
        write_reg(REG_FORMAT, CFG_W'(FMT_UNUSED));
        send_word(32'hFFFF_FFFF);
        send_word(32'h1234_5678);
        settle();
        write_reg(REG_FORMAT, CFG_W'(FMT_RGB565));
        write_reg(REG_SPARE, 13'd0);
        send_word(32'hFFFF_FFFF);
        send_word(32'h07E0_F81F);
        settle();
    endtask

    task automatic test_size_limits();
        src_gaps   = 1;
        snk_stalls = 1;
        write_reg(REG_HEIGHT, 13'd1);
        write_reg(REG_WIDTH, 13'd0);
        repeat (3) send_word(rand_word());
        settle();
        write_reg(REG_WIDTH, 13'd1);
        repeat (2) send_word(rand_word());
        settle();
        write_reg(REG_WIDTH, 13'd3);
        repeat (2) send_word(rand_word());
        settle();
        write_reg(REG_WIDTH, 13'd7);
        write_reg(REG_HEIGHT, 13'd0);
        repeat (6) send_word(rand_word());
        settle();

        // oversized limits saturate, back to back
        src_gaps   = 0;
        snk_stalls = 0;
        write_reg(REG_WIDTH, 13'd2);
        repeat (2) send_word(rand_word());
        settle();
        write_reg(REG_HEIGHT, 13'h1FFF);
        repeat (4) send_word(rand_word());
        settle();
        write_reg(REG_HEIGHT, 13'd1);
        write_reg(REG_WIDTH, 13'h1FFF);
        repeat (4) send_word(rand_word());
        settle();

        // shrink limits while inside a line and a frame
        src_gaps   = 1;
        snk_stalls = 1;
        write_reg(REG_WIDTH, 13'd4096);
        write_reg(REG_HEIGHT, 13'd4096);
        repeat (9) send_word(rand_word());
        settle();
        write_reg(REG_WIDTH, 13'd6);
        write_reg(REG_HEIGHT, 13'd2);
        repeat (8) send_word(rand_word());
        settle();
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] val;
        int               n;
        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            if ($urandom_range(0, 3) != 0)
            begin
                val = CFG_W'($urandom());
                val[1:0] = ($urandom_range(0, 7) == 0) ? FMT_UNUSED : 2'($urandom_range(0, 2));
                write_reg(REG_FORMAT, val);
            end
            case ($urandom_range(0, 9))
                0: val = 13'd0;
                1: val = 13'd1;
                2: val = 13'd4096;
                3: val = 13'h1FFF;
                default: val = CFG_W'($urandom_range(2, 24));
            endcase
            write_reg(REG_WIDTH, val);
            case ($urandom_range(0, 9))
                0: val = 13'd0;
                1: val = 13'd4096;
                2: val = 13'h1FFF;
                default: val = CFG_W'($urandom_range(1, 6));
            endcase
            write_reg(REG_HEIGHT, val);
            if ($urandom_range(0, 4) == 0)
                write_reg(REG_SPARE, 13'($urandom()));
            src_gaps   = $urandom_range(0, 2) != 0;
            snk_stalls = $urandom_range(0, 2) != 0;
            n = 8;
            for (int i = 0; i < n; i++)
            begin
                if ((i == n / 2 && ph % 3 == 0) || $urandom_range(0, 199) == 0)
                    settle();
                send_word(rand_word());
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = REG_FORMAT;
        cfg_data   = '0;
        data_valid = 1'b0;
        data_word  = '0;
        src_gaps   = 0;
        snk_stalls = 0;
        cur_fmt    = RST_FORMAT;
        cur_width  = RST_WIDTH;
        cur_height = RST_HEIGHT;
        exp_col    = 0;
        exp_row    = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_formats();
        test_size_limits();
        test_random_traffic();

        data_valid <= 1'b0;
        for (int k = 0; k < 5000 && pending_pairs.size() != 0; k++)
            @(posedge clk);
        if (pending_pairs.size() != 0)
            flag_error("pairs never delivered", 0, pending_pairs.size());
        repeat (10) @(posedge clk);

        $display("covered: %0d words, %0d pairs checked, %0d line ends, %0d frame ends",
                 words_sent, pairs_checked, eol_seen, eof_seen);
        $display("formats YUYV/UYVY/RGB565/unused, size saturation, mid-frame limit changes");
        if (errors == 0)
            $display("tb_packed_pixel_to_rgb888_core: done, clean");
        else
            $display("tb_packed_pixel_to_rgb888_core: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ppr_pkg.sv
hw/rtl/ppr_lane.sv
hw/rtl/ppr_frame_ctr.sv
hw/rtl/packed_pixel_to_rgb888_core.sv
sim/tb_packed_pixel_to_rgb888_core.sv
